// ----- src/ubxfr_pkg.sv -----
// shared types and constants for the ubx frame receiver
package ubxfr_pkg;

   localparam int NUM_KINDS = 4;
   localparam int KIND_W    = 2;

   localparam logic [7:0]  SYNC1_BYTE = 8'hB5;
   localparam logic [7:0]  SYNC2_BYTE = 8'h62;
   localparam logic [7:0]  CLASS_NAV  = 8'h01;
   localparam logic [7:0]  ID_POSLLH  = 8'h02;
   localparam logic [7:0]  ID_VELNED  = 8'h12;
   localparam logic [7:0]  ID_STATUS  = 8'h03;
   localparam logic [7:0]  ID_SVINFO  = 8'h30;
   localparam logic [15:0] LEN_POSLLH = 16'd28;
   localparam logic [15:0] LEN_VELNED = 16'd36;
   localparam logic [15:0] LEN_STATUS = 16'd16;

   localparam logic [KIND_W-1:0] KIND_POSLLH = 2'd0;
   localparam logic [KIND_W-1:0] KIND_VELNED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;
   localparam logic [KIND_W-1:0] KIND_SVINFO = 2'd3;

   localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
   localparam logic [7:0]  TIMEOUT_RESET = 8'd50;

   typedef enum logic [2:0] {
      PH_SYNC1,
      PH_SYNC2,
      PH_CLASS,
      PH_ID,
      PH_LEN,
      PH_PAYLOAD,
      PH_CKA,
      PH_CKB
   } phase_type;

   typedef enum logic [1:0] {
      ACT_BYTE,
      ACT_TICK,
      ACT_READ,
      ACT_NOP
   } action_type;

   typedef enum logic [2:0] {
      EV_NONE,
      EV_GOOD,
      EV_CKSUM_BAD,
      EV_BAD_CLASS,
      EV_BAD_ID,
      EV_SYNC1_DROP,
      EV_SYNC2_DROP
   } event_type;

   typedef struct packed {
      event_type         event_res;
      logic [KIND_W-1:0] msg_kind;
      logic              have_message;
      logic [15:0]       good_count;
      logic              timed_out;
      logic              rd_hit;
   } rsp_info_type;

endpackage

// ----- src/ubxfr_payload_mem.sv -----
// payload store: one write port, one read port with registered read data
module ubxfr_payload_mem
   import ubxfr_pkg::*;
#(
   parameter int ADDR_W = 11
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [7:0] payload_mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         payload_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= payload_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/ubxfr_parser.sv -----
// frame parser, fletcher-8 check, bank and count bookkeeping, tick counter
module ubxfr_parser
   import ubxfr_pkg::*;
#(
   parameter int MAX_PAYLOAD = 256,
   parameter int OFF_W       = 8,
   parameter int ADDR_W      = 11
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic [1:0]           action,
   input  logic [7:0]           data_byte,
   input  logic [KIND_W-1:0]    read_kind,
   input  logic [7:0]           read_offset,
   input  logic [7:0]           timeout_limit,
   output rsp_info_type         info,
   output logic                 mem_wr_en,
   output logic [ADDR_W-1:0]    mem_wr_addr,
   output logic [7:0]           mem_wr_data,
   output logic                 mem_rd_en,
   output logic [ADDR_W-1:0]    mem_rd_addr
);

   localparam int          IDX_W   = $clog2(MAX_PAYLOAD + 1);
   localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

   phase_type         phase_ff, phase_in;
   logic [7:0]        class_ff, class_in;
   logic [7:0]        id_ff, id_in;
   logic [7:0]        len_lo_ff, len_lo_in;
   logic              len_idx_ff, len_idx_in;
   logic [IDX_W-1:0]  frame_len_ff, frame_len_in;
   logic [7:0]        sum_a_ff, sum_a_in;
   logic [7:0]        sum_b_ff, sum_b_in;
   logic [7:0]        rcv_a_ff, rcv_a_in;
   logic [IDX_W-1:0]  pidx_ff, pidx_in;
   logic [KIND_W-1:0] cur_kind_ff, cur_kind_in;
   logic [NUM_KINDS-1:0] bank_ff, bank_in;
   logic [15:0]       count_ff [NUM_KINDS];
   logic [7:0]        tick_ff, tick_in;

   action_type        act;
   logic              byte_fire;
   logic [15:0]       full_len;
   event_type         hdr_ev;
   logic [KIND_W-1:0] hdr_kind;
   logic [IDX_W-1:0]  pidx_next;
   logic              ck_good;
   logic [7:0]        add_a, add_b;
   logic [KIND_W-1:0] kind_sel;
   logic              sel_bank;
   logic [15:0]       sel_cnt, cnt_inc, cnt_out;
   logic              cnt_we;
   logic              rd_in_range;
   event_type         ev;

   assign act       = action_type'(action);
   assign byte_fire = fire && (act == ACT_BYTE);
   assign full_len  = {data_byte, len_lo_ff};
   assign pidx_next = pidx_ff + IDX_W'(1);
   assign ck_good   = (rcv_a_ff == sum_a_ff) && (data_byte == sum_b_ff);
   assign add_a     = sum_a_ff + data_byte;
   assign add_b     = sum_b_ff + add_a;

   // one kind selects the count and bank entry for every action
   assign kind_sel = (act == ACT_READ) ? read_kind : cur_kind_in;
   assign sel_bank = bank_ff[kind_sel];
   assign sel_cnt  = count_ff[kind_sel];
   assign cnt_inc  = (sel_cnt == COUNT_MAX) ? sel_cnt : sel_cnt + 16'd1;
   assign cnt_out  = cnt_we ? cnt_inc : sel_cnt;
   assign rd_in_range = 16'(read_offset) < MAX_LEN;

   // header classification once the second length byte arrives
   always_comb begin
      hdr_ev   = EV_BAD_ID;
      hdr_kind = cur_kind_ff;
      priority if (class_ff != CLASS_NAV) begin
         hdr_ev = EV_BAD_CLASS;
      end else if (id_ff == ID_POSLLH && full_len == LEN_POSLLH) begin
         hdr_ev   = EV_NONE;
         hdr_kind = KIND_POSLLH;
      end else if (id_ff == ID_VELNED && full_len == LEN_VELNED) begin
         hdr_ev   = EV_NONE;
         hdr_kind = KIND_VELNED;
      end else if (id_ff == ID_STATUS && full_len == LEN_STATUS) begin
         hdr_ev   = EV_NONE;
         hdr_kind = KIND_STATUS;
      end else if (id_ff == ID_SVINFO && full_len <= MAX_LEN) begin
         hdr_ev   = EV_NONE;
         hdr_kind = KIND_SVINFO;
      end else begin
         hdr_ev = EV_BAD_ID;
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (byte_fire) begin
         unique case (phase_ff)
            PH_SYNC1: begin
               if (data_byte == SYNC1_BYTE) phase_in = PH_SYNC2;
            end
            PH_SYNC2: begin
               priority if (data_byte == SYNC2_BYTE) phase_in = PH_CLASS;
               else if (data_byte != SYNC1_BYTE) phase_in = PH_SYNC1;
               else phase_in = PH_SYNC2;
            end
            PH_CLASS: phase_in = PH_ID;
            PH_ID:    phase_in = PH_LEN;
            PH_LEN: begin
               if (len_idx_ff) begin
                  priority if (hdr_ev != EV_NONE) phase_in = PH_SYNC1;
                  else if (full_len == 16'd0) phase_in = PH_CKA;
                  else phase_in = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               if (pidx_next >= frame_len_ff) phase_in = PH_CKA;
            end
            PH_CKA: phase_in = PH_CKB;
            PH_CKB: phase_in = PH_SYNC1;
         endcase
      end
   end

   // datapath and event per transaction
   always_comb begin
      class_in     = class_ff;
      id_in        = id_ff;
      len_lo_in    = len_lo_ff;
      len_idx_in   = len_idx_ff;
      frame_len_in = frame_len_ff;
      sum_a_in     = sum_a_ff;
      sum_b_in     = sum_b_ff;
      rcv_a_in     = rcv_a_ff;
      pidx_in      = pidx_ff;
      cur_kind_in  = cur_kind_ff;
      bank_in      = bank_ff;
      tick_in      = tick_ff;
      cnt_we       = 1'b0;
      ev           = EV_NONE;
      mem_wr_en    = 1'b0;
      mem_rd_en    = 1'b0;
      if (fire) begin
         unique case (act)
            ACT_BYTE: begin
               unique case (phase_ff)
                  PH_SYNC1: begin
                     if (data_byte != SYNC1_BYTE) ev = EV_SYNC1_DROP;
                  end
                  PH_SYNC2: begin
                     priority if (data_byte == SYNC2_BYTE) begin
                        sum_a_in = 8'd0;
                        sum_b_in = 8'd0;
                     end else if (data_byte != SYNC1_BYTE) begin
                        ev = EV_SYNC2_DROP;
                     end else begin
                        // repeated sync 1 keeps waiting
                        ev = EV_NONE;
                     end
                  end
                  PH_CLASS: begin
                     class_in = data_byte;
                     sum_a_in = add_a;
                     sum_b_in = add_b;
                  end
                  PH_ID: begin
                     id_in      = data_byte;
                     sum_a_in   = add_a;
                     sum_b_in   = add_b;
                     len_idx_in = 1'b0;
                  end
                  PH_LEN: begin
                     sum_a_in = add_a;
                     sum_b_in = add_b;
                     if (!len_idx_ff) begin
                        len_lo_in  = data_byte;
                        len_idx_in = 1'b1;
                     end else begin
                        len_idx_in   = 1'b0;
                        pidx_in      = '0;
                        frame_len_in = IDX_W'(full_len);
                        ev           = hdr_ev;
                        if (hdr_ev == EV_NONE) cur_kind_in = hdr_kind;
                     end
                  end
                  PH_PAYLOAD: begin
                     mem_wr_en = 1'b1;
                     sum_a_in  = add_a;
                     sum_b_in  = add_b;
                     pidx_in   = pidx_next;
                  end
                  PH_CKA: begin
                     rcv_a_in = data_byte;
                  end
                  PH_CKB: begin
                     if (ck_good) begin
                        cnt_we            = 1'b1;
                        tick_in           = 8'd0;
                        bank_in[kind_sel] = ~sel_bank;
                        ev                = EV_GOOD;
                     end else begin
                        ev = EV_CKSUM_BAD;
                     end
                  end
               endcase
            end
            ACT_TICK: begin
               if (tick_ff < timeout_limit) tick_in = tick_ff + 8'd1;
            end
            ACT_READ: begin
               mem_rd_en = 1'b1;
            end
            ACT_NOP: begin
            end
         endcase
      end
   end

   // payload goes to the spare bank, reads come from the live bank
   assign mem_wr_addr = {kind_sel, ~sel_bank, OFF_W'(pidx_ff)};
   assign mem_wr_data = data_byte;
   assign mem_rd_addr = {kind_sel, sel_bank, OFF_W'(read_offset)};

   always_comb begin
      info.event_res    = ev;
      info.msg_kind     = kind_sel;
      info.good_count   = cnt_out;
      info.have_message = cnt_out != 16'd0;
      info.timed_out    = tick_in == timeout_limit;
      info.rd_hit       = (act == ACT_READ) && (sel_cnt != 16'd0) && rd_in_range;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SYNC1;
         class_ff     <= '0;
         id_ff        <= '0;
         len_lo_ff    <= '0;
         len_idx_ff   <= 1'b0;
         frame_len_ff <= '0;
         sum_a_ff     <= '0;
         sum_b_ff     <= '0;
         rcv_a_ff     <= '0;
         pidx_ff      <= '0;
         cur_kind_ff  <= '0;
         bank_ff      <= '0;
         tick_ff      <= '0;
         for (int k = 0; k < NUM_KINDS; k++) begin
            count_ff[k] <= '0;
         end
      end else begin
         phase_ff     <= phase_in;
         class_ff     <= class_in;
         id_ff        <= id_in;
         len_lo_ff    <= len_lo_in;
         len_idx_ff   <= len_idx_in;
         frame_len_ff <= frame_len_in;
         sum_a_ff     <= sum_a_in;
         sum_b_ff     <= sum_b_in;
         rcv_a_ff     <= rcv_a_in;
         pidx_ff      <= pidx_in;
         cur_kind_ff  <= cur_kind_in;
         bank_ff      <= bank_in;
         tick_ff      <= tick_in;
         if (cnt_we) begin
            count_ff[kind_sel] <= cnt_inc;
         end
      end
   end

endmodule

// ----- src/ubxfr_resp_pipe.sv -----
// result pipeline: memory-aligned stage plus output register
module ubxfr_resp_pipe
   import ubxfr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rsp_info_type      push_info,
   input  logic [7:0]        mem_rd_data,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_event_res,
   output logic [KIND_W-1:0] rsp_msg_kind,
   output logic [7:0]        rsp_read_data,
   output logic              rsp_have_message,
   output logic [15:0]       rsp_good_count,
   output logic              rsp_timed_out
);

   logic         p1_valid_ff, p1_valid_in;
   rsp_info_type p1_info_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_info_type rsp_info_ff;
   logic [7:0]   rsp_data_ff;
   logic         rsp_load;

   assign rsp_load     = !rsp_valid_ff || !rsp_stall;
   assign req_stall    = p1_valid_ff && !rsp_load;
   assign p1_valid_in  = push || (p1_valid_ff && !rsp_load);
   assign rsp_valid_in = p1_valid_ff || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff  <= p1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         p1_info_ff <= push_info;
      end
      // read data lines up with the first stage, held since no read issues meanwhile
      if (p1_valid_ff && rsp_load) begin
         rsp_info_ff <= p1_info_ff;
         rsp_data_ff <= p1_info_ff.rd_hit ? mem_rd_data : 8'd0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_res    = rsp_info_ff.event_res;
   assign rsp_msg_kind     = rsp_info_ff.msg_kind;
   assign rsp_read_data    = rsp_data_ff;
   assign rsp_have_message = rsp_info_ff.have_message;
   assign rsp_good_count   = rsp_info_ff.good_count;
   assign rsp_timed_out    = rsp_info_ff.timed_out;

`ifndef SYNTH
   a_stall_needs_stage: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> p1_valid_ff)
      else $error("input stalled with empty first stage");

   a_push_not_stalled: assert property (@(posedge clock) disable iff (reset)
      push |-> !req_stall)
      else $error("transaction pushed while stalled");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      push |=> p1_valid_ff)
      else $error("pushed transaction lost");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (p1_valid_ff && rsp_valid_ff && rsp_stall) |=> (p1_valid_ff && $stable(p1_info_ff)))
      else $error("first stage changed while output stalled");
`endif

endmodule

// ----- src/ubx_frame_receiver_core.sv -----
// top level: ubx frame receiver with double-buffered payload store
// pipeline: accepted transactions pass the first stage, then the output register
// throughput: one transaction per cycle when not stalled, bytes, ticks and reads
//   alike; one write per payload byte and one read per read, on separate store ports
// reset: synchronous, clears parser, counts, banks, tick counter and pipeline
//   valids; timeout limit returns to 50; the payload store is not cleared
module ubx_frame_receiver_core
   import ubxfr_pkg::*;
#(
   parameter int MAX_PAYLOAD = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_action,
   input  logic [7:0]        req_data_byte,
   input  logic [KIND_W-1:0] req_read_kind,
   input  logic [7:0]        req_read_offset,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_event_res,
   output logic [KIND_W-1:0] rsp_msg_kind,
   output logic [7:0]        rsp_read_data,
   output logic              rsp_have_message,
   output logic [15:0]       rsp_good_count,
   output logic              rsp_timed_out,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_timeout_limit
);

   localparam int OFF_W  = $clog2(MAX_PAYLOAD);
   localparam int ADDR_W = KIND_W + 1 + OFF_W;

   logic              fire;
   logic [7:0]        timeout_limit_ff;
   rsp_info_type      info;
   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [7:0]        mem_wr_data;
   logic              mem_rd_en;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [7:0]        mem_rd_data;

   assign fire      = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_limit_ff <= TIMEOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         timeout_limit_ff <= csr_timeout_limit;
      end
   end

   ubxfr_parser #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .OFF_W       (OFF_W),
      .ADDR_W      (ADDR_W)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .action        (req_action),
      .data_byte     (req_data_byte),
      .read_kind     (req_read_kind),
      .read_offset   (req_read_offset),
      .timeout_limit (timeout_limit_ff),
      .info          (info),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data),
      .mem_rd_en     (mem_rd_en),
      .mem_rd_addr   (mem_rd_addr)
   );

   ubxfr_payload_mem #(
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   ubxfr_resp_pipe u_resp (
      .clock            (clock),
      .reset            (reset),
      .push             (fire),
      .push_info        (info),
      .mem_rd_data      (mem_rd_data),
      .req_stall        (req_stall),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_res    (rsp_event_res),
      .rsp_msg_kind     (rsp_msg_kind),
      .rsp_read_data    (rsp_read_data),
      .rsp_have_message (rsp_have_message),
      .rsp_good_count   (rsp_good_count),
      .rsp_timed_out    (rsp_timed_out)
   );

endmodule

// ----- sim/tb_top.sv -----
// testbench for the ubx frame receiver core: random and directed traffic against a scoreboard
module tb_top;
   import ubxfr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_PAYLOAD = 256;
   localparam int HOLD_CYCLES = 150;

   typedef struct packed {
      action_type  action;
      logic [7:0]  data_byte;
      logic [1:0]  read_kind;
      logic [7:0]  read_offset;
   } ubx_req_t;

   typedef struct packed {
      event_type   ev;
      logic [1:0]  kind;
      logic [7:0]  data;
      logic        have;
      logic [15:0] count;
      logic        timed_out;
   } ubx_rsp_t;

   class ubx_scoreboard;
      logic [7:0]  timeout_limit;
      phase_type   parse_state;
      logic [7:0]  frame_class;
      logic [7:0]  frame_id;
      logic [15:0] frame_length;
      logic        length_hi;
      logic [7:0]  fl_a;
      logic [7:0]  fl_b;
      logic [7:0]  rx_fl_a;
      int unsigned payload_pos;
      logic [1:0]  cur_kind;
      logic        bank_sel [NUM_KINDS];
      logic [15:0] good_counts [NUM_KINDS];
      logic [7:0]  tick_count;
      logic [7:0]  store [NUM_KINDS][2][MAX_PAYLOAD];
      bit          written [NUM_KINDS][2][MAX_PAYLOAD];
      ubx_rsp_t    pending_results [$];
      int          mismatches;

      function new();
         timeout_limit = TIMEOUT_RESET;
         parse_state   = PH_SYNC1;
         frame_class   = '0;
         frame_id      = '0;
         frame_length  = '0;
         length_hi     = 1'b0;
         fl_a          = '0;
         fl_b          = '0;
         rx_fl_a       = '0;
         payload_pos   = 0;
         cur_kind      = KIND_POSLLH;
         tick_count    = '0;
         mismatches    = 0;
         for (int k = 0; k < NUM_KINDS; k++) begin
            bank_sel[k]    = 1'b0;
            good_counts[k] = '0;
         end
      endfunction

      function void add_to_sum(logic [7:0] b);
         fl_a = fl_a + b;
         fl_b = fl_b + fl_a;
      endfunction

      // kind is only taken over when the header is accepted
      function event_type classify_header();
         if (frame_class != CLASS_NAV)
            return EV_BAD_CLASS;
         if (frame_id == ID_POSLLH && frame_length == LEN_POSLLH) begin
            cur_kind = KIND_POSLLH;
            return EV_NONE;
         end
         if (frame_id == ID_VELNED && frame_length == LEN_VELNED) begin
            cur_kind = KIND_VELNED;
            return EV_NONE;
         end
         if (frame_id == ID_STATUS && frame_length == LEN_STATUS) begin
            cur_kind = KIND_STATUS;
            return EV_NONE;
         end
         if (frame_id == ID_SVINFO && frame_length <= MAX_PAYLOAD) begin
            cur_kind = KIND_SVINFO;
            return EV_NONE;
         end
         return EV_BAD_ID;
      endfunction

      function event_type parse_byte(logic [7:0] b);
         event_type ev;
         logic [1:0] k;
         ev = EV_NONE;
         k  = cur_kind;
         case (parse_state)
            PH_SYNC1: begin
               if (b == SYNC1_BYTE) parse_state = PH_SYNC2;
               else ev = EV_SYNC1_DROP;
            end
            PH_SYNC2: begin
               if (b == SYNC2_BYTE) begin
                  fl_a = '0;
                  fl_b = '0;
                  parse_state = PH_CLASS;
               end else if (b != SYNC1_BYTE) begin
                  ev = EV_SYNC2_DROP;
                  parse_state = PH_SYNC1;
               end
            end
            PH_CLASS: begin
               frame_class = b;
               add_to_sum(b);
               parse_state = PH_ID;
            end
            PH_ID: begin
               frame_id = b;
               add_to_sum(b);
               frame_length = '0;
               length_hi = 1'b0;
               parse_state = PH_LEN;
            end
            PH_LEN: begin
               add_to_sum(b);
               if (!length_hi) begin
                  frame_length = {8'h00, b};
                  length_hi = 1'b1;
               end else begin
                  frame_length[15:8] = b;
                  length_hi = 1'b0;
                  payload_pos = 0;
                  ev = classify_header();
                  if (ev != EV_NONE) parse_state = PH_SYNC1;
                  else if (frame_length == 0) parse_state = PH_CKA;
                  else parse_state = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               k = cur_kind;
               // payload goes to the spare bank
               store[k][bank_sel[k] ^ 1'b1][payload_pos] = b;
               written[k][bank_sel[k] ^ 1'b1][payload_pos] = 1'b1;
               add_to_sum(b);
               payload_pos++;
               if (payload_pos >= frame_length) parse_state = PH_CKA;
            end
            PH_CKA: begin
               rx_fl_a = b;
               parse_state = PH_CKB;
            end
            default: begin
               k = cur_kind;
               if (rx_fl_a == fl_a && b == fl_b) begin
                  if (good_counts[k] != COUNT_MAX) good_counts[k]++;
                  tick_count = '0;
                  bank_sel[k] = bank_sel[k] ^ 1'b1;
                  ev = EV_GOOD;
               end else begin
                  ev = EV_CKSUM_BAD;
               end
               parse_state = PH_SYNC1;
            end
         endcase
         return ev;
      endfunction

      function void note_request(ubx_req_t r);
         ubx_rsp_t e;
         logic [1:0] k;
         e.ev   = EV_NONE;
         e.data = '0;
         k = cur_kind;
         case (r.action)
            ACT_BYTE: begin
               e.ev = parse_byte(r.data_byte);
               k = cur_kind;
            end
            ACT_TICK: if (tick_count < timeout_limit) tick_count++;
            ACT_READ: begin
               k = r.read_kind;
               if (good_counts[k] != 0 && r.read_offset < MAX_PAYLOAD)
                  e.data = store[k][bank_sel[k]][r.read_offset];
            end
            default: ;
         endcase
         e.kind      = k;
         e.have      = (good_counts[k] != 0);
         e.count     = good_counts[k];
         e.timed_out = (tick_count == timeout_limit);
         pending_results.push_back(e);
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(ubx_rsp_t got);
         ubx_rsp_t want;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none actual event %0d kind %0d",
                     $time, got.ev, got.kind);
            mismatches++;
            return;
         end
         want = pending_results.pop_front();
         compare_field("event_res", 16'(want.ev), 16'(got.ev));
         compare_field("msg_kind", 16'(want.kind), 16'(got.kind));
         compare_field("read_data", 16'(want.data), 16'(got.data));
         compare_field("have_message", 16'(want.have), 16'(got.have));
         compare_field("good_count", want.count, got.count);
         compare_field("timed_out", 16'(want.timed_out), 16'(got.timed_out));
      endfunction

      // finds an offset whose current bank entry has been written; any offset before a good message
      function bit pick_offset(logic [1:0] k, output logic [7:0] off);
         logic [7:0] o;
         int start;
         off = 8'($urandom_range(0, 255));
         if (good_counts[k] == 0) return 1'b1;
         for (int i = 0; i < 8; i++) begin
            o = (i < 4) ? 8'($urandom_range(0, 40)) : 8'($urandom_range(0, 255));
            if (written[k][bank_sel[k]][o]) begin
               off = o;
               return 1'b1;
            end
         end
         start = $urandom_range(0, 255);
         for (int i = 0; i < MAX_PAYLOAD; i++) begin
            o = 8'(start + i);
            if (written[k][bank_sel[k]][o]) begin
               off = o;
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function int pending_count();
         return pending_results.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_action = '0;
   logic [7:0]        req_data_byte = '0;
   logic [KIND_W-1:0] req_read_kind = '0;
   logic [7:0]        req_read_offset = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [2:0]        rsp_event_res;
   logic [KIND_W-1:0] rsp_msg_kind;
   logic [7:0]        rsp_read_data;
   logic              rsp_have_message;
   logic [15:0]       rsp_good_count;
   logic              rsp_timed_out;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [7:0]        csr_timeout_limit = '0;

   ubx_scoreboard sb;
   int burst_left = 0;
   bit quiet = 1'b0;
   int items_sent = 0;
   int hold_requests = 0;
   int holds_started = 0;
   int holds_done = 0;

   ubx_frame_receiver_core #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_data_byte(req_data_byte),
      .req_read_kind(req_read_kind),
      .req_read_offset(req_read_offset),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_event_res(rsp_event_res),
      .rsp_msg_kind(rsp_msg_kind),
      .rsp_read_data(rsp_read_data),
      .rsp_have_message(rsp_have_message),
      .rsp_good_count(rsp_good_count),
      .rsp_timed_out(rsp_timed_out),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_timeout_limit(csr_timeout_limit)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      ubx_rsp_t got;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         got.ev        = event_type'(rsp_event_res);
         got.kind      = rsp_msg_kind;
         got.data      = rsp_read_data;
         got.have      = rsp_have_message;
         got.count     = rsp_good_count;
         got.timed_out = rsp_timed_out;
         sb.check_response(got);
      end
   end

   // receiver back-pressure: random patterns, plus a long hold when asked for
   initial begin
      int mode;
      int len;
      forever begin
         if (holds_done != hold_requests) begin
            rsp_stall <= 1'b1;
            holds_started = hold_requests;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done = hold_requests;
         end else begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(1, 40);
            repeat (len) begin
               case (mode)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(0, 3) == 0);
                  2: rsp_stall <= 1'($urandom_range(0, 1));
                  default: rsp_stall <= ($urandom_range(0, 3) != 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   initial begin
      #1ms;
      $display("tb_top: errors");
      $finish;
   end

   task automatic send_item(input ubx_req_t r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (quiet || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_action      <= r.action;
      req_data_byte   <= r.data_byte;
      req_read_kind   <= r.read_kind;
      req_read_offset <= r.read_offset;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_request(r);
      if (r.action != ACT_NOP) items_sent++;
   endtask

   // fields unused by the action carry random values
   task automatic send_action(input action_type a, input logic [7:0] b);
      ubx_req_t r;
      r.action      = a;
      r.data_byte   = b;
      r.read_kind   = 2'($urandom_range(0, 3));
      r.read_offset = 8'($urandom_range(0, 255));
      send_item(r);
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_action(ACT_BYTE, b);
   endtask

   task automatic send_tick();
      send_action(ACT_TICK, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_read(input logic [1:0] k, input logic [7:0] off);
      ubx_req_t r;
      r.action      = ACT_READ;
      r.data_byte   = 8'($urandom_range(0, 255));
      r.read_kind   = k;
      r.read_offset = off;
      send_item(r);
   endtask

   task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                             input logic [15:0] len, input bit with_body, input bit bad_sum);
      logic [7:0] ck_a;
      logic [7:0] ck_b;
      logic [7:0] p;
      logic [7:0] hdr [4];
      ck_a = '0;
      ck_b = '0;
      hdr = '{cls, id, len[7:0], len[15:8]};
      send_byte(SYNC1_BYTE);
      send_byte(SYNC2_BYTE);
      foreach (hdr[i]) begin
         send_byte(hdr[i]);
         ck_a = ck_a + hdr[i];
         ck_b = ck_b + ck_a;
      end
      if (with_body) begin
         for (int i = 0; i < len; i++) begin
            p = 8'($urandom_range(0, 255));
            send_byte(p);
            ck_a = ck_a + p;
            ck_b = ck_b + ck_a;
         end
         if (bad_sum) begin
            if ($urandom_range(0, 1)) ck_a = ck_a ^ (8'h01 << $urandom_range(0, 7));
            else ck_b = ck_b ^ (8'h01 << $urandom_range(0, 7));
         end
         send_byte(ck_a);
         send_byte(ck_b);
      end
   endtask

   task automatic send_random_frame();
      int pick;
      bit bad;
      logic [15:0] len;
      logic [7:0] cls;
      logic [7:0] id;
      pick = $urandom_range(0, 99);
      bad  = ($urandom_range(0, 9) == 0);
      if (pick < 18) send_frame(CLASS_NAV, ID_POSLLH, LEN_POSLLH, 1'b1, bad);
      else if (pick < 34) send_frame(CLASS_NAV, ID_VELNED, LEN_VELNED, 1'b1, bad);
      else if (pick < 50) send_frame(CLASS_NAV, ID_STATUS, LEN_STATUS, 1'b1, bad);
      else if (pick < 82) begin
         case ($urandom_range(0, 9))
            0: len = 16'(MAX_PAYLOAD);
            1: len = 16'($urandom_range(13, MAX_PAYLOAD - 1));
            default: len = 16'($urandom_range(0, 12));
         endcase
         send_frame(CLASS_NAV, ID_SVINFO, len, 1'b1, bad);
      end else if (pick < 89) begin
         cls = 8'($urandom_range(0, 255));
         if (cls == CLASS_NAV) cls = 8'hFF;
         send_frame(cls, ID_POSLLH, LEN_POSLLH, 1'b0, 1'b0);
      end else begin
         case ($urandom_range(0, 2))
            0: begin
               id = 8'($urandom_range(0, 255));
               if (id == ID_POSLLH || id == ID_VELNED || id == ID_STATUS || id == ID_SVINFO)
                  id = 8'h00;
               len = 16'($urandom_range(0, 40));
            end
            1: begin
               // known id with one length bit wrong
               case ($urandom_range(0, 2))
                  0: begin id = ID_POSLLH; len = LEN_POSLLH; end
                  1: begin id = ID_VELNED; len = LEN_VELNED; end
                  default: begin id = ID_STATUS; len = LEN_STATUS; end
               endcase
               len = len ^ (16'h0001 << $urandom_range(0, 15));
            end
            default: begin
               id  = ID_SVINFO;
               len = 16'($urandom_range(MAX_PAYLOAD + 1, 16'hFFFF));
            end
         endcase
         send_frame(CLASS_NAV, id, len, 1'b0, 1'b0);
      end
   endtask

   task automatic send_random_read();
      logic [1:0] k;
      logic [7:0] off;
      k = 2'($urandom_range(0, 3));
      for (int i = 0; i < NUM_KINDS; i++) begin
         if (sb.pick_offset(k, off)) begin
            send_read(k, off);
            return;
         end
         k = k + 2'd1;
      end
      send_tick();
   endtask

   task automatic send_noise();
      int n;
      n = $urandom_range(1, 6);
      repeat (n) begin
         case ($urandom_range(0, 7))
            0, 1: send_byte(SYNC1_BYTE);
            2: send_byte(SYNC2_BYTE);
            default: send_byte(8'($urandom_range(0, 255)));
         endcase
      end
   endtask

   task automatic random_traffic(input int n);
      int target;
      int pick;
      target = items_sent + n;
      while (items_sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) send_random_frame();
         else if (pick < 65) send_random_read();
         else if (pick < 78) repeat ($urandom_range(1, 8)) send_tick();
         else if (pick < 95) send_noise();
         else send_action(ACT_NOP, 8'($urandom_range(0, 255)));
      end
   endtask

   // sender stops until every result is back and the pipeline is empty
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending_count() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_timeout_limit(input logic [7:0] v);
      csr_valid         <= 1'b1;
      csr_timeout_limit <= v;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      sb.timeout_limit = v;
   endtask

   initial begin
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty reads, odd actions, sync handling, zero-length frames and header rejects
      send_read(KIND_POSLLH, 8'h00);
      send_read(KIND_SVINFO, 8'hFF);
      send_action(ACT_NOP, 8'hFF);
      send_tick();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(SYNC1_BYTE);
      send_byte(8'h00);
      send_byte(SYNC1_BYTE);
      send_byte(SYNC1_BYTE);
      send_frame(CLASS_NAV, ID_SVINFO, 16'd0, 1'b1, 1'b0);
      send_frame(CLASS_NAV, ID_SVINFO, 16'd0, 1'b1, 1'b1);
      send_frame(CLASS_NAV, ID_SVINFO, 16'(MAX_PAYLOAD + 1), 1'b0, 1'b0);
      send_frame(8'hFF, ID_POSLLH, LEN_POSLLH, 1'b0, 1'b0);
      send_frame(CLASS_NAV, 8'h00, 16'hFFFF, 1'b0, 1'b0);

      settle();
      write_timeout_limit(8'd1);
      random_traffic(100);

      // saturate the tick count at its limit, then lower the limit under it
      settle();
      write_timeout_limit(8'd40);
      quiet = 1'b1;
      repeat (44) send_tick();
      quiet = 1'b0;
      settle();
      write_timeout_limit(8'd10);
      send_tick();
      send_random_read();
      send_frame(CLASS_NAV, ID_STATUS, LEN_STATUS, 1'b1, 1'b0);
      send_tick();

      // long receiver hold while the sender keeps offering
      settle();
      hold_requests++;
      while (holds_started != hold_requests) @(posedge clock);
      quiet = 1'b1;
      random_traffic(60);
      quiet = 1'b0;

      settle();
      write_timeout_limit(8'($urandom_range(2, 254)));
      random_traffic(100);

      settle();
      write_timeout_limit(TIMEOUT_RESET);
      random_traffic(60);

      settle();
      if (sb.mismatches == 0 && sb.pending_count() == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
